// ===== hdl/sls_pkg.sv =====
// Package for the sequential list store: payload structs, command and status codes,
// and the control and status structs between the controller and the datapath.
// It has no dependencies.
package sls_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [6:0]         index;
        logic signed [31:0] value;
    } sls_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [7:0]         length;
    } sls_out_t;

    typedef struct packed {
        logic       load_in;
        logic       append_wr;
        logic       update_wr;
        logic       rd_idx;
        logic       del_start;
        logic       shift_step;
        logic       dec_count;
        logic       res_load;
        logic       res_from_mem;
        logic [1:0] res_status;
    } sls_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       idx_bad;
        logic       del_more;
        logic       shift_more;
    } sls_stat_t;

endpackage

// ===== hdl/sls_dp.sv =====
// Datapath of the sequential list store: entry memory, element count, shift pointer,
// latched input beat and the registered result beat.
// It depends on sls_pkg.
module sls_dp #(
    parameter int DEPTH = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sls_pkg::sls_in_t  s_data,
    input  sls_pkg::sls_ctl_t ctl,
    output sls_pkg::sls_stat_t stat,
    output sls_pkg::sls_out_t m_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    logic [31:0]          mem [DEPTH];
    sls_pkg::sls_in_t     in_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [AW-1:0]        sp_reg;
    logic [AW-1:0]        sp_next;
    logic [31:0]          rdata_reg;
    sls_pkg::sls_out_t    out_reg;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [31:0]          wr_data;
    logic [AW-1:0]        rd_addr;
    logic [CMPW-1:0]      idx_ext;
    logic [CMPW-1:0]      cnt_ext;
    logic [CMPW-1:0]      sp_ext;

    assign idx_ext = CMPW'(in_reg.index);
    assign cnt_ext = CMPW'(count_reg);
    assign sp_ext  = CMPW'(sp_reg);

    assign stat.cmd        = in_reg.cmd;
    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.idx_bad    = (idx_ext >= cnt_ext);
    assign stat.del_more   = ((idx_ext + CMPW'(1)) < cnt_ext);
    assign stat.shift_more = ((sp_ext + CMPW'(2)) < cnt_ext);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sp_reg;
        wr_data = rdata_reg;
        rd_addr = AW'(sp_ext + CMPW'(2));
        sp_next = sp_reg;
        count_next = count_reg;
        if (ctl.append_wr) begin
            wr_en      = 1'b1;
            wr_addr    = AW'(count_reg);
            wr_data    = in_reg.value;
            count_next = count_reg + CW'(1);
        end
        if (ctl.update_wr) begin
            wr_en   = 1'b1;
            wr_addr = AW'(in_reg.index);
            wr_data = in_reg.value;
        end
        if (ctl.rd_idx) begin
            rd_addr = AW'(in_reg.index);
        end
        if (ctl.del_start) begin
            rd_addr = AW'(idx_ext + CMPW'(1));
            sp_next = AW'(in_reg.index);
        end
        if (ctl.shift_step) begin
            wr_en   = 1'b1;
            sp_next = sp_reg + AW'(1);
        end
        if (ctl.dec_count) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        sp_reg <= sp_next;
        if (ctl.load_in) begin
            in_reg <= s_data;
        end
        if (ctl.res_load) begin
            out_reg.status     <= ctl.res_status;
            out_reg.read_value <= ctl.res_from_mem ? rdata_reg : 32'sd0;
            out_reg.length     <= 8'(count_next);
        end
    end

    assign m_data = out_reg;

endmodule

// ===== hdl/sls_ctrl.sv =====
// Controller of the sequential list store: a one-hot state machine that drives
// the datapath and the channel handshakes.
// It depends on sls_pkg.
module sls_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  sls_pkg::sls_stat_t stat,
    output sls_pkg::sls_ctl_t  ctl
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_READ  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_RESP);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.res_status = sls_pkg::ST_DONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.cmd == sls_pkg::CMD_APPEND) begin
                    ctl.res_load = 1'b1;
                    state_next   = S_RESP;
                    if (stat.full) begin
                        ctl.res_status = sls_pkg::ST_FULL;
                    end else begin
                        ctl.append_wr = 1'b1;
                    end
                end else if (stat.idx_bad) begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = sls_pkg::ST_BAD_INDEX;
                    state_next     = S_RESP;
                end else if (stat.cmd == sls_pkg::CMD_DELETE) begin
                    if (stat.del_more) begin
                        ctl.del_start = 1'b1;
                        state_next    = S_SHIFT;
                    end else begin
                        ctl.dec_count = 1'b1;
                        ctl.res_load  = 1'b1;
                        state_next    = S_RESP;
                    end
                end else if (stat.cmd == sls_pkg::CMD_UPDATE) begin
                    ctl.update_wr = 1'b1;
                    ctl.res_load  = 1'b1;
                    state_next    = S_RESP;
                end else begin
                    ctl.rd_idx = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                ctl.res_load     = 1'b1;
                ctl.res_from_mem = 1'b1;
                state_next       = S_RESP;
            end
            S_SHIFT: begin
                ctl.shift_step = 1'b1;
                if (!stat.shift_more) begin
                    ctl.dec_count = 1'b1;
                    ctl.res_load  = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sequential_list_store_top.sv =====
// Sequential list store top level, built from sls_pkg, sls_ctrl and sls_dp.
// The result beat is registered in the execute state for append, update, rejected and
// tail delete commands, in the read state for a read, and otherwise in the last shift
// state of a delete, which moves the entries one at a time (up to DEPTH-1 of them), paced
// by the single memory write port. The next beat is accepted the cycle after the result
// beat is taken. Synchronous active-low reset empties the list.
module sequential_list_store_top #(
    parameter int DEPTH = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sls_pkg::sls_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sls_pkg::sls_out_t m_data
);

    sls_pkg::sls_ctl_t  ctl;
    sls_pkg::sls_stat_t stat;

    sls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    sls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctl     (ctl),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// ===== dv/sequential_list_store_top_tb.sv =====
// Self-checking testbench for sequential_list_store_top: it drives command beats, predicts
// each result from its own copy of the list and compares every result beat field by field.
// It depends on sls_pkg and on the RTL of the sequential list store.
module sequential_list_store_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 128;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sls_pkg::sls_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sls_pkg::sls_out_t m_data;

    sls_pkg::sls_in_t  queued_commands[$];
    sls_pkg::sls_out_t awaited_results[$];

    logic [31:0] list_words[LIST_DEPTH];
    int          list_len = 0;
    int          plan_len = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    logic        hold_go = 1'b0;
    int          hold_left = 0;

    sequential_list_store_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one command to the list copy and returns the result it should give.
    function automatic sls_pkg::sls_out_t list_apply(sls_pkg::sls_in_t item);
        sls_pkg::sls_out_t res;
        int                pos;
        res = '0;
        pos = int'(item.index);
        if (item.cmd == sls_pkg::CMD_APPEND) begin
            if (list_len >= LIST_DEPTH) begin
                res.status = sls_pkg::ST_FULL;
            end else begin
                list_words[list_len] = item.value;
                list_len++;
            end
        end else if (pos >= list_len) begin
            res.status = sls_pkg::ST_BAD_INDEX;
        end else if (item.cmd == sls_pkg::CMD_DELETE) begin
            for (int i = pos; i + 1 < list_len; i++) begin
                list_words[i] = list_words[i + 1];
            end
            list_len--;
        end else if (item.cmd == sls_pkg::CMD_UPDATE) begin
            list_words[pos] = item.value;
        end else begin
            res.read_value = list_words[pos];
        end
        res.length = list_len[7:0];
        return res;
    endfunction

    task automatic plan_command(logic [1:0] cmd, int pos, logic [31:0] word);
        sls_pkg::sls_in_t item;
        item.cmd = cmd;
        item.index = pos[6:0];
        item.value = word;
        queued_commands.push_back(item);
        if (cmd == sls_pkg::CMD_APPEND) begin
            if (plan_len < LIST_DEPTH) begin
                plan_len++;
            end
        end else if (cmd == sls_pkg::CMD_DELETE && pos < plan_len) begin
            plan_len--;
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_index();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80 && plan_len > 0) begin
            return $urandom_range(plan_len - 1);
        end else if (roll < 90 && plan_len < LIST_DEPTH) begin
            return $urandom_range(LIST_DEPTH - 1, plan_len);
        end
        return $urandom_range(LIST_DEPTH - 1);
    endfunction

    // The list grows towards full and then shrinks towards empty, so that both ends are
    // reached repeatedly, with updates, reads and out-of-range indices mixed in.
    task automatic plan_walk(int count);
        bit growing;
        int roll;
        growing = (plan_len < LIST_DEPTH / 2);
        for (int n = 0; n < count; n++) begin
            if (growing && plan_len == LIST_DEPTH && $urandom_range(9) == 0) begin
                growing = 1'b0;
            end else if (!growing && plan_len == 0 && $urandom_range(3) == 0) begin
                growing = 1'b1;
            end
            roll = $urandom_range(99);
            if (growing) begin
                if (roll < 65) begin
                    plan_command(sls_pkg::CMD_APPEND, $urandom_range(LIST_DEPTH - 1),
                                 pick_word());
                end else if (roll < 75) begin
                    plan_command(sls_pkg::CMD_DELETE, pick_index(), pick_word());
                end else if (roll < 87) begin
                    plan_command(sls_pkg::CMD_UPDATE, pick_index(), pick_word());
                end else begin
                    plan_command(sls_pkg::CMD_READ, pick_index(), pick_word());
                end
            end else begin
                if (roll < 55) begin
                    plan_command(sls_pkg::CMD_DELETE, pick_index(), pick_word());
                end else if (roll < 70) begin
                    plan_command(sls_pkg::CMD_APPEND, $urandom_range(LIST_DEPTH - 1),
                                 pick_word());
                end else if (roll < 85) begin
                    plan_command(sls_pkg::CMD_UPDATE, pick_index(), pick_word());
                end else begin
                    plan_command(sls_pkg::CMD_READ, pick_index(), pick_word());
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (queued_commands.size() != 0 || awaited_results.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : command_driver
        sls_pkg::sls_in_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(list_apply(s_data));
            end
            if (!s_valid || s_ready) begin
                if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = queued_commands.pop_front();
                    s_valid <= 1'b1;
                    s_data <= next_item;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_monitor
        sls_pkg::sls_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result beat status=%0d read_value=%0d length=%0d",
                             $realtime, m_data.status, m_data.read_value, m_data.length);
                end
            end else begin
                want = awaited_results.pop_front();
                if (m_data.status !== want.status || m_data.read_value !== want.read_value ||
                    m_data.length !== want.length) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result mismatch: expected status=%0d read_value=%0d",
                                 $realtime, want.status, want.read_value);
                        $display("    expected length=%0d, got status=%0d read_value=%0d",
                                 want.length, m_data.status, m_data.read_value);
                        $display("    got length=%0d", m_data.length);
                    end
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("sequential_list_store_top regression: fail");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        plan_command(sls_pkg::CMD_READ, 0, 32'h1234_5678);
        plan_command(sls_pkg::CMD_DELETE, LIST_DEPTH - 1, 32'h0);
        plan_command(sls_pkg::CMD_UPDATE, 0, 32'hdead_beef);
        plan_command(sls_pkg::CMD_APPEND, 0, 32'h8000_0000);
        plan_command(sls_pkg::CMD_APPEND, 0, 32'h7fff_ffff);
        plan_command(sls_pkg::CMD_APPEND, LIST_DEPTH - 1, 32'h0000_0000);
        plan_command(sls_pkg::CMD_APPEND, 0, 32'hffff_ffff);
        plan_command(sls_pkg::CMD_READ, 0, 32'h0);
        plan_command(sls_pkg::CMD_READ, 3, 32'h0);
        plan_command(sls_pkg::CMD_READ, 4, 32'h0);
        plan_command(sls_pkg::CMD_UPDATE, 1, 32'h5555_5555);
        plan_command(sls_pkg::CMD_READ, 1, 32'h0);
        plan_command(sls_pkg::CMD_DELETE, 0, 32'h0);
        plan_command(sls_pkg::CMD_READ, 0, 32'h0);
        plan_command(sls_pkg::CMD_DELETE, 2, 32'h0);
        plan_command(sls_pkg::CMD_READ, 2, 32'h0);
        plan_command(sls_pkg::CMD_UPDATE, LIST_DEPTH - 1, 32'haaaa_aaaa);
        plan_command(sls_pkg::CMD_DELETE, 1, 32'h0);
        plan_command(sls_pkg::CMD_READ, 0, 32'h0);
        plan_command(sls_pkg::CMD_DELETE, 0, 32'h0);
        plan_command(sls_pkg::CMD_READ, 0, 32'h0);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        plan_walk(290);
        repeat (60) @(posedge aclk);
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        wait_drained();

        send_idle_pct = 57;
        recv_stall_pct = 0;
        plan_walk(290);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 57;
        plan_walk(290);
        wait_drained();

        send_idle_pct = 11;
        recv_stall_pct = 11;
        plan_walk(290);
        wait_drained();

        repeat (200) @(posedge aclk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("sequential_list_store_top regression: pass");
        end else begin
            $display("sequential_list_store_top regression: fail");
        end
        $finish;
    end

endmodule
